FILE: rtl/lpi_pkg.sv
`timescale 1ns / 1ps
package lpi_pkg;
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;
   localparam int CSR_IDX_WIDTH   = 3;

   typedef logic [CSR_IDX_WIDTH-1:0] csr_idx_type;

   localparam csr_idx_type CSR_PLANE_PT_X = 3'd0;
   localparam csr_idx_type CSR_PLANE_PT_Y = 3'd1;
   localparam csr_idx_type CSR_PLANE_PT_Z = 3'd2;
   localparam csr_idx_type CSR_PLANE_N_X  = 3'd3;
   localparam csr_idx_type CSR_PLANE_N_Y  = 3'd4;
   localparam csr_idx_type CSR_PLANE_N_Z  = 3'd5;
endpackage

FILE: rtl/line_plane_intersection_core.sv
`timescale 1ns / 1ps
// Line / plane intersection, signed fixed point (COORD_WIDTH bits, FRAC_BITS
// fraction bits).
// The plane (reference point and normal) is written through the csr_ port:
// csr_we, csr_index (0..5 = pt x,y,z, normal x,y,z), csr_wdata. Writes take
// effect at once; write only while no transaction is in flight.
// Requests arrive on req_ (valid/ready): req_type 0 = start plus direction,
// 1 = start plus end point. Each request gives one rsp_ transaction with the
// hit point, is_parallel and saturated.
// Pipeline: COORD_WIDTH + 9 register stages.
// Throughput: one transaction per cycle while rsp_ready is high; the
// quotient is formed by a pipelined restoring divider, one quotient bit
// per stage. When rsp_ready is low, filled stages hold and empty stages
// keep filling, so req_ready drops only once every stage holds a
// transaction.
// Reset clears all stage valid bits and returns the plane to point 0,
// normal (0, 0, 1.0).
module line_plane_intersection_core #(
   parameter int COORD_WIDTH = lpi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = lpi_pkg::FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  lpi_pkg::csr_idx_type           csr_index,
   input  logic [COORD_WIDTH-1:0]         csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_type,
   input  logic signed [COORD_WIDTH-1:0]  req_start_x,
   input  logic signed [COORD_WIDTH-1:0]  req_start_y,
   input  logic signed [COORD_WIDTH-1:0]  req_start_z,
   input  logic signed [COORD_WIDTH-1:0]  req_second_x,
   input  logic signed [COORD_WIDTH-1:0]  req_second_y,
   input  logic signed [COORD_WIDTH-1:0]  req_second_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [COORD_WIDTH-1:0]  rsp_hit_x,
   output logic signed [COORD_WIDTH-1:0]  rsp_hit_y,
   output logic signed [COORD_WIDTH-1:0]  rsp_hit_z,
   output logic                           rsp_is_parallel,
   output logic                           rsp_saturated
);
   import lpi_pkg::*;

   localparam int W    = COORD_WIDTH;
   localparam int F    = FRAC_BITS;
   localparam int SW   = W + 1;
   localparam int PW   = 2 * SW;
   localparam int SUMW = PW + 2;
   localparam int NW   = SUMW + F;
   localparam int ND   = W + 1;
   localparam int DW   = NW + ND + 1;
   localparam int KW   = W + SW;
   localparam int HW   = KW + 1;
   localparam int QW   = ND + 1;
   localparam int NS   = ND + 8;
   localparam int ST_OVF = 4;
   localparam int ST_RND = 5 + ND;
   localparam int ST_KD  = 6 + ND;
   localparam int ST_OUT = 7 + ND;

   // plane registers
   logic signed [W-1:0] pt_ff [3];
   logic signed [W-1:0] n_ff  [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pt_ff[0] <= '0;
         pt_ff[1] <= '0;
         pt_ff[2] <= '0;
         n_ff[0]  <= '0;
         n_ff[1]  <= '0;
         n_ff[2]  <= W'(1) << F;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PLANE_PT_X: pt_ff[0] <= csr_wdata;
            CSR_PLANE_PT_Y: pt_ff[1] <= csr_wdata;
            CSR_PLANE_PT_Z: pt_ff[2] <= csr_wdata;
            CSR_PLANE_N_X:  n_ff[0]  <= csr_wdata;
            CSR_PLANE_N_Y:  n_ff[1]  <= csr_wdata;
            CSR_PLANE_N_Z:  n_ff[2]  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valids and advance chain
   logic [NS-1:0] v_ff;
   logic [NS-1:0] adv;

   assign adv[NS-1] = !v_ff[NS-1] || rsp_ready;
   generate
      for (genvar i = 0; i < NS - 1; i++) begin : g_adv
         assign adv[i] = !v_ff[i] || adv[i+1];
      end
   endgenerate

   assign req_ready = adv[0];
   assign rsp_valid = v_ff[NS-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (adv[0]) v_ff[0] <= req_valid;
         for (int i = 1; i < NS; i++) begin
            if (adv[i]) v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // carried payload
   logic signed [W-1:0]  s_ff   [NS][3];
   logic signed [SW-1:0] d_ff   [NS][3];
   logic [SUMW-1:0]      dm_ff  [NS];
   logic                 par_ff [NS];
   logic                 neg_ff [NS];
   logic                 ovf_ff [NS];

   logic signed [W-1:0] start_a  [3];
   logic signed [W-1:0] second_a [3];
   assign start_a[0]  = req_start_x;
   assign start_a[1]  = req_start_y;
   assign start_a[2]  = req_start_z;
   assign second_a[0] = req_second_x;
   assign second_a[1] = req_second_y;
   assign second_a[2] = req_second_z;

   // stage 0: direction and start minus plane point
   logic signed [SW-1:0] sp_ff [3];
   logic signed [SW-1:0] d_in  [3];
   logic signed [SW-1:0] sp_in [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         d_in[a] = req_type ? (SW'(second_a[a]) - SW'(start_a[a])) : SW'(second_a[a]);
         sp_in[a] = SW'(start_a[a]) - SW'(pt_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         for (int a = 0; a < 3; a++) begin
            s_ff[0][a] <= start_a[a];
            d_ff[0][a] <= d_in[a];
            sp_ff[a]   <= sp_in[a];
         end
      end
   end

   generate
      for (genvar i = 1; i < NS; i++) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv[i]) begin
               s_ff[i] <= s_ff[i-1];
               d_ff[i] <= d_ff[i-1];
            end
         end
      end
      for (genvar i = 4; i < NS; i++) begin : g_carry_div
         always_ff @(posedge clock) begin
            if (adv[i]) begin
               dm_ff[i]  <= dm_ff[i-1];
               par_ff[i] <= par_ff[i-1];
               neg_ff[i] <= neg_ff[i-1];
            end
         end
      end
      for (genvar i = ST_OVF + 1; i < NS; i++) begin : g_carry_ovf
         always_ff @(posedge clock) begin
            if (adv[i]) ovf_ff[i] <= ovf_ff[i-1];
         end
      end
   endgenerate

   // stage 1: products
   logic signed [PW-1:0] pn_ff [3];
   logic signed [PW-1:0] pd_ff [3];

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         for (int a = 0; a < 3; a++) begin
            pn_ff[a] <= PW'(SW'(n_ff[a]) * sp_ff[a]);
            pd_ff[a] <= PW'(SW'(n_ff[a]) * d_ff[0][a]);
         end
      end
   end

   // stage 2: dot products
   logic signed [SUMW-1:0] num_ff;
   logic signed [SUMW-1:0] den_ff;

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         num_ff <= SUMW'(pn_ff[0]) + SUMW'(pn_ff[1]) + SUMW'(pn_ff[2]);
         den_ff <= SUMW'(pd_ff[0]) + SUMW'(pd_ff[1]) + SUMW'(pd_ff[2]);
      end
   end

   // stage 3: magnitudes
   logic [NW-1:0]   nm_ff;
   logic [SUMW-1:0] num_mag;
   logic [SUMW-1:0] den_mag;

   assign num_mag = num_ff[SUMW-1] ? SUMW'(-num_ff) : SUMW'(num_ff);
   assign den_mag = den_ff[SUMW-1] ? SUMW'(-den_ff) : SUMW'(den_ff);

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         nm_ff     <= NW'(num_mag) << F;
         dm_ff[3]  <= den_mag;
         par_ff[3] <= (den_ff == '0);
         neg_ff[3] <= num_ff[SUMW-1] ^ den_ff[SUMW-1];
      end
   end

   // stage 4: quotient overflow check, divider seed
   logic [NW-1:0] rem_ff [ND+1];
   logic [QW-1:0] q_ff   [ND+1];

   always_ff @(posedge clock) begin
      if (adv[ST_OVF]) begin
         ovf_ff[ST_OVF] <= DW'(nm_ff) >= (DW'(dm_ff[3]) << ND);
         rem_ff[0]      <= nm_ff;
         q_ff[0]        <= '0;
      end
   end

   // divider: one quotient bit per stage, MSB first
   generate
      for (genvar j = 0; j < ND; j++) begin : g_div
         localparam int B = ND - 1 - j;
         logic [DW-1:0] trial;
         logic          take;
         assign trial = DW'(dm_ff[ST_OVF + j]) << B;
         assign take  = DW'(rem_ff[j]) >= trial;
         always_ff @(posedge clock) begin
            if (adv[ST_OVF + 1 + j]) begin
               rem_ff[j+1] <= take ? NW'(DW'(rem_ff[j]) - trial) : rem_ff[j];
               q_ff[j+1]   <= take ? (q_ff[j] | (QW'(1) << B)) : q_ff[j];
            end
         end
      end
   endgenerate

   // round, sign and clip k
   logic signed [W-1:0] k_ff;
   logic                ksat_ff;
   logic [QW-1:0]       q_rnd;
   logic [QW-1:0]       k_lim;
   logic [QW-1:0]       k_mag;
   logic                k_sat;

   always_comb begin
      q_rnd = q_ff[ND] + QW'((DW'(rem_ff[ND]) << 1) >= DW'(dm_ff[ST_RND-1]));
      k_lim = neg_ff[ST_RND-1] ? (QW'(1) << (W - 1)) : ((QW'(1) << (W - 1)) - QW'(1));
      k_sat = ovf_ff[ST_RND-1] || (q_rnd > k_lim);
      k_mag = k_sat ? k_lim : q_rnd;
   end

   always_ff @(posedge clock) begin
      if (adv[ST_RND]) begin
         k_ff    <= neg_ff[ST_RND-1] ? W'(-k_mag) : W'(k_mag);
         ksat_ff <= k_sat;
      end
   end

   // k times direction
   logic signed [KW-1:0] kd_ff [3];
   logic                 ksat2_ff;

   always_ff @(posedge clock) begin
      if (adv[ST_KD]) begin
         for (int a = 0; a < 3; a++) begin
            kd_ff[a] <= KW'(SW'(k_ff) * d_ff[ST_KD-1][a]);
         end
         ksat2_ff <= ksat_ff;
      end
   end

   // hit point and output register
   logic signed [W-1:0] hit_ff [3];
   logic                par_o_ff;
   logic                sat_o_ff;
   logic signed [W-1:0] hit_in [3];
   logic                sat_in;
   logic signed [KW-1:0] t_r;
   logic signed [HW-1:0] h_w;
   logic signed [HW-1:0] h_max;
   logic signed [HW-1:0] h_min;

   assign h_max = HW'((KW'(1) << (W - 1)) - KW'(1));
   assign h_min = -h_max - HW'(1);

   always_comb begin
      sat_in = ksat2_ff;
      t_r    = '0;
      h_w    = '0;
      for (int a = 0; a < 3; a++) begin
         t_r = (kd_ff[a] + (KW'(1) << (F - 1))) >>> F;
         h_w = HW'(s_ff[ST_OUT-1][a]) - HW'(t_r);
         if (h_w > h_max) begin
            hit_in[a] = W'(h_max);
            sat_in    = 1'b1;
         end else if (h_w < h_min) begin
            hit_in[a] = W'(h_min);
            sat_in    = 1'b1;
         end else begin
            hit_in[a] = W'(h_w);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         for (int a = 0; a < 3; a++) begin
            hit_ff[a] <= par_ff[ST_OUT-1] ? '0 : hit_in[a];
         end
         par_o_ff <= par_ff[ST_OUT-1];
         sat_o_ff <= par_ff[ST_OUT-1] ? 1'b0 : sat_in;
      end
   end

   assign rsp_hit_x       = hit_ff[0];
   assign rsp_hit_y       = hit_ff[1];
   assign rsp_hit_z       = hit_ff[2];
   assign rsp_is_parallel = par_o_ff;
   assign rsp_saturated   = sat_o_ff;

   a_par_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_parallel |-> !rsp_saturated && rsp_hit_x == '0
         && rsp_hit_y == '0 && rsp_hit_z == '0)
      else $error("parallel result not cleared");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("req_ready low with empty output stage");

   a_reset_clears: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");
endmodule
